// File: src/cpfd_pkg.sv
// Shared types and constants of the chained pointer fixup decoder.
package cpfd_pkg;

  // Pointer format codes.
  localparam logic [3:0] FMT_ARM64E        = 4'd1;
  localparam logic [3:0] FMT_GEN64         = 4'd2;
  localparam logic [3:0] FMT_GEN64_OFFSET  = 4'd6;
  localparam logic [3:0] FMT_ARM64E_USER24 = 4'd12;

  // Upper fill of a negative 19-bit addend.
  localparam logic [63:0] SEXT19_FILL = 64'hffff_ffff_fff8_0000;

  // Request kinds carried in tuser.
  localparam logic ACTION_LOAD   = 1'b0;
  localparam logic ACTION_DECODE = 1'b1;

  // Field widths of the streams.
  localparam int unsigned IN_DATA_W  = 144;
  localparam int unsigned OUT_DATA_W = 104;

  typedef enum logic [1:0] {
    KIND_REBASE      = 2'd0,
    KIND_BIND        = 2'd1,
    KIND_AUTH_REBASE = 2'd2,
    KIND_AUTH_BIND   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    REG_FORMAT    = 2'd0,
    REG_ACTUAL    = 2'd1,
    REG_PREFERRED = 2'd2
  } reg_e;

  // Configuration as seen by the decoder.
  typedef struct packed {
    logic [3:0]  fmt;
    logic [63:0] actual_base;
    logic [63:0] slide;
  } cfg_t;

  // Decoded request, held in the table read stage.
  typedef struct packed {
    logic        is_load;
    logic        load_wr;
    logic        use_table;
    logic        ord_err;
    logic [23:0] ordinal;
    logic [63:0] base;
    logic [63:0] addend;
    logic [13:0] step;
    logic        chain_end;
    logic        sign_needed;
    logic [1:0]  key;
    logic [15:0] diversity;
    logic        blend;
  } dec_t;

endpackage

// File: src/chained_pointer_fixup_decoder.sv
// Top level of the chained pointer fixup decoder.
// An accepted request goes through stage 1, which waits on the table read, and then
// through the output register to the result stream. Throughput: one request per cycle
// while the sink is ready; only bind forms read the single-port import table.
// A load request writes the import table at its accept edge, so a following bind sees it.
// Reset clears the pipeline valids and the registers (format 1, bases 0).
// The import table is not cleared by reset and holds undefined data until loaded.
module chained_pointer_fixup_decoder
  import cpfd_pkg::*;
#(
  parameter int unsigned IMPORT_DEPTH = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Request stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: import_index[11:0], import_value[75:12], slot_word[139:76], zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: action[0]
  input  logic [0:0]            s_axis_tuser,
  // Result stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata: fixed_value[63:0], byte_step[77:64], chain_end[78], sign_needed[79],
  //        sign_key[81:80], sign_diversity[97:82], sign_address_blend[98],
  //        ordinal_error[99], zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // Configuration port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [63:0]           pwdata,
  output logic [63:0]           prdata,
  output logic                  pready
);

  localparam int unsigned AW = (IMPORT_DEPTH > 1) ? $clog2(IMPORT_DEPTH) : 1;

  cfg_t        cfg;
  dec_t        dec;
  logic        in_acc;
  logic        adv;
  logic        ram_we;
  logic        ram_re;
  logic [23:0] addr_full;
  logic [AW-1:0] ram_addr;
  logic [63:0] ram_rdata;

  // Stage 1: decoded request waiting on the table read data.
  logic        s1_valid_q, s1_valid_d;
  dec_t        s1_q;

  // Output register.
  logic                  out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic [OUT_DATA_W-1:0] out_data_d;
  logic [63:0]           value;

  assign pready = 1'b1;

  cpfd_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  cpfd_decode #(
    .IMPORT_DEPTH (IMPORT_DEPTH)
  ) u_decode (
    .cfg_i          (cfg),
    .action_i       (s_axis_tuser[0]),
    .import_index_i (s_axis_tdata[11:0]),
    .slot_word_i    (s_axis_tdata[139:76]),
    .dec_o          (dec)
  );

  // The pipeline moves whenever the output register is free or being drained.
  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Loads and decodes share the one RAM port; an accept is one or the other.
  assign ram_we    = in_acc && dec.load_wr;
  assign ram_re    = in_acc && dec.use_table && !dec.ord_err;
  assign addr_full = dec.is_load ? {12'd0, s_axis_tdata[11:0]} : dec.ordinal;
  assign ram_addr  = addr_full[AW-1:0];

  cpfd_ram #(
    .WIDTH (64),
    .DEPTH (IMPORT_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (s_axis_tdata[75:12]),
    .rdata_o (ram_rdata)
  );

  // The RAM read data holds while stage 1 stalls, since no new read is issued.
  always_comb begin
    value = s1_q.use_table ? (ram_rdata + s1_q.addend) : (s1_q.base + s1_q.addend);
    if (s1_q.ord_err || s1_q.is_load) begin
      value = 64'd0;
    end
    out_data_d = {4'd0, s1_q.ord_err, s1_q.blend, s1_q.diversity, s1_q.key,
                  s1_q.sign_needed, s1_q.chain_end, s1_q.step, value};
  end

  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = s1_valid_q;
      s1_valid_d  = in_acc;
    end else if (in_acc) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= dec;
    end
    if (adv && s1_valid_q) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
  // A full stage 1 that cannot move must hold off new requests.
  a_stall_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !adv) |-> !s_axis_tready)
    else $error("request accepted while stage 1 is stalled");

  // Every accepted request occupies stage 1 on the next cycle.
  a_accept_fills_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_valid_q)
    else $error("accepted request lost before stage 1");

  // An out-of-range ordinal always yields a zero value.
  a_err_zero_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[99]) |-> (m_axis_tdata[63:0] == 64'd0))
    else $error("ordinal error with nonzero value");

  // Signer fields are zero unless signing is requested.
  a_sign_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[79]) |-> (m_axis_tdata[98:80] == 19'd0))
    else $error("signer fields set without sign request");
`endif

endmodule

// File: src/cpfd_ram.sv
// Generic single-port RAM with registered read data.
module cpfd_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/cpfd_cfg.sv
// Configuration register file with its APB-style access port.
module cpfd_cfg
  import cpfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [4:0]  paddr_i,
  input  logic [63:0] pwdata_i,
  output logic [63:0] prdata_o,
  output cfg_t        cfg_o
);

  logic [3:0]  fmt_q, fmt_d;
  logic [63:0] actual_q, actual_d;
  logic [63:0] preferred_q, preferred_d;
  logic        wr;
  reg_e        sel;

  assign wr  = psel_i & penable_i & pwrite_i;
  assign sel = reg_e'(paddr_i[4:3]);

  always_comb begin
    fmt_d       = fmt_q;
    actual_d    = actual_q;
    preferred_d = preferred_q;
    prdata_o    = 64'd0;
    unique case (sel)
      REG_FORMAT: begin
        prdata_o = {60'd0, fmt_q};
        if (wr) fmt_d = pwdata_i[3:0];
      end
      REG_ACTUAL: begin
        prdata_o = actual_q;
        if (wr) actual_d = pwdata_i;
      end
      REG_PREFERRED: begin
        prdata_o = preferred_q;
        if (wr) preferred_d = pwdata_i;
      end
      default: begin
        prdata_o = 64'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q       <= FMT_ARM64E;
      actual_q    <= 64'd0;
      preferred_q <= 64'd0;
    end else begin
      fmt_q       <= fmt_d;
      actual_q    <= actual_d;
      preferred_q <= preferred_d;
    end
  end

  assign cfg_o.fmt         = fmt_q;
  assign cfg_o.actual_base = actual_q;
  assign cfg_o.slide       = actual_q - preferred_q;

endmodule

// File: src/cpfd_decode.sv
// Field extraction of one slot word under the configured pointer format.
module cpfd_decode
  import cpfd_pkg::*;
#(
  parameter int unsigned IMPORT_DEPTH = 4096
) (
  input  cfg_t        cfg_i,
  input  logic        action_i,
  input  logic [11:0] import_index_i,
  input  logic [63:0] slot_word_i,
  output dec_t        dec_o
);

  localparam logic [24:0] DEPTH_LIM = 25'(IMPORT_DEPTH);

  logic [63:0] w;
  logic        gen;
  logic [23:0] arm_ord;
  logic [10:0] next11;
  logic [11:0] next12;
  kind_e       kind;

  assign w       = slot_word_i;
  assign gen     = (cfg_i.fmt == FMT_GEN64) || (cfg_i.fmt == FMT_GEN64_OFFSET);
  assign arm_ord = (cfg_i.fmt == FMT_ARM64E_USER24) ? w[23:0] : {8'd0, w[15:0]};
  assign next11  = w[61:51];
  assign next12  = w[62:51];
  assign kind    = kind_e'(w[63:62]);

  always_comb begin
    dec_o             = '0;
    dec_o.is_load     = (action_i == ACTION_LOAD);
    dec_o.load_wr     = (action_i == ACTION_LOAD) &&
                        ({13'd0, import_index_i} < DEPTH_LIM);
    if (gen) begin
      dec_o.step      = {next12, 2'b00};
      dec_o.chain_end = (next12 == 12'd0);
      if (!w[63]) begin
        dec_o.addend = {w[43:36], 20'd0, w[35:0]};
        dec_o.base   = (cfg_i.fmt == FMT_GEN64_OFFSET) ? cfg_i.actual_base : cfg_i.slide;
      end else begin
        dec_o.use_table = 1'b1;
        dec_o.ordinal   = w[23:0];
        dec_o.addend    = {56'd0, w[31:24]};
      end
    end else begin
      dec_o.step      = {next11, 3'b000};
      dec_o.chain_end = (next11 == 11'd0);
      dec_o.ordinal   = arm_ord;
      unique case (kind)
        KIND_REBASE: begin
          dec_o.ordinal = 24'd0;
          dec_o.addend  = {w[50:43], 13'd0, w[42:0]};
          dec_o.base    = (cfg_i.fmt == FMT_ARM64E) ? cfg_i.slide : cfg_i.actual_base;
        end
        KIND_BIND: begin
          dec_o.use_table = 1'b1;
          dec_o.addend    = {45'd0, w[50:32]} | (w[50] ? SEXT19_FILL : 64'd0);
        end
        KIND_AUTH_REBASE: begin
          // preferred_base + target + slide folds to actual_base + target.
          dec_o.ordinal     = 24'd0;
          dec_o.base        = cfg_i.actual_base;
          dec_o.addend      = {32'd0, w[31:0]};
          dec_o.sign_needed = 1'b1;
          dec_o.diversity   = w[47:32];
          dec_o.blend       = w[48];
          dec_o.key         = w[50:49];
        end
        KIND_AUTH_BIND: begin
          dec_o.use_table   = 1'b1;
          dec_o.sign_needed = 1'b1;
          dec_o.diversity   = w[47:32];
          dec_o.blend       = w[48];
          dec_o.key         = w[50:49];
        end
        default: begin
          dec_o.use_table = 1'b0;
        end
      endcase
    end
    dec_o.ord_err = dec_o.use_table && ({1'b0, dec_o.ordinal} >= DEPTH_LIM);
    if (dec_o.is_load) begin
      dec_o.use_table   = 1'b0;
      dec_o.ord_err     = 1'b0;
      dec_o.ordinal     = 24'd0;
      dec_o.step        = 14'd0;
      dec_o.chain_end   = 1'b0;
      dec_o.sign_needed = 1'b0;
      dec_o.key         = 2'd0;
      dec_o.diversity   = 16'd0;
      dec_o.blend       = 1'b0;
    end
  end

endmodule
